// ===== design/priority_timing_wheel_assert.svh =====
// Assertion macros for the priority timing wheel.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef PRIORITY_TIMING_WHEEL_ASSERT_SVH
`define PRIORITY_TIMING_WHEEL_ASSERT_SVH

// Property that must hold at every clock edge.
`define PTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ptw_pkg.sv =====
// Shared types and constants for the priority timing wheel.
// No dependencies; imported by ptw_slot_store and priority_timing_wheel.
`timescale 1ns / 1ps

package ptw_pkg;

  // Number of wheel slots; must be a power of two.
  localparam int unsigned WHEEL_SLOTS = 256;
  localparam int unsigned ADDR_W      = $clog2(WHEEL_SLOTS);
  localparam int unsigned DEV_W       = 2;
  localparam int unsigned PAY_W       = 32;
  localparam int unsigned DELAY_W     = 8;

  localparam logic [DEV_W-1:0] IDLE_CODE = 2'd3;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [1:0] ST_SCHEDULED = 2'd0;
  localparam logic [1:0] ST_DROPPED   = 2'd1;
  localparam logic [1:0] ST_CLOCK     = 2'd2;
  localparam logic [1:0] ST_EVENT     = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [DEV_W-1:0]   device_code;
    logic [PAY_W-1:0]   payload;
    logic [DELAY_W-1:0] delay;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [DEV_W-1:0] disp_device;
    logic [PAY_W-1:0] event_payload;
  } out_word_t;

  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [PAY_W-1:0] payload;
  } slot_t;

  // Access request from the sequencer to the slot store.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    slot_t             wr_slot;
  } slot_req_t;

endpackage

// ===== design/ptw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptw_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/ptw_slot_store.sv =====
// Slot store: wheel RAM plus one valid bit per slot, so unwritten slots read idle.
// Depends on ptw_pkg and ptw_ram.
`timescale 1ns / 1ps

module ptw_slot_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptw_pkg::slot_req_t req_i,
  output ptw_pkg::slot_t    rd_slot_o
);

  import ptw_pkg::*;

  logic [WHEEL_SLOTS-1:0] valid_q;
  logic                   rd_valid_q;
  logic [$bits(slot_t)-1:0] ram_rd_data;
  slot_t                  ram_slot;

  ptw_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(WHEEL_SLOTS)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (req_i.wr_en),
    .wr_addr_i(req_i.wr_addr),
    .wr_data_i(req_i.wr_slot),
    .rd_en_i  (req_i.rd_en),
    .rd_addr_i(req_i.rd_addr),
    .rd_data_o(ram_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign ram_slot = slot_t'(ram_rd_data);

  // A slot never written since reset holds the idle code and a zero argument.
  always_comb begin
    if (rd_valid_q) begin
      rd_slot_o = ram_slot;
    end else begin
      rd_slot_o.device  = IDLE_CODE;
      rd_slot_o.payload = '0;
    end
  end

endmodule

// ===== design/priority_timing_wheel.sv =====
// Priority timing wheel: a slot walk sequencer over one compare/advance unit.
// Depends on ptw_pkg, ptw_slot_store and priority_timing_wheel_assert.svh.
//
// Usage: one input channel (in_valid_i / in_stall_o, in_word_i) carries schedule
// and dispatch words; one output channel (out_valid_o / out_stall_i, out_word_o)
// returns exactly one result word per input word, in order.
// A schedule word reads one slot per cycle starting at pointer plus delay,
// comparing each slot's device code against the carried entry and swapping
// where it finds a lower priority slot. Each carry visits at most the wheel
// size in slots. A clock-phase dispatch reads no slot; a device-event
// dispatch does one slot read, then writes back the idle code. The next word
// is taken in the cycle after the result is loaded. The slot RAM read port
// sets the one-slot-per-cycle walk rate.
// in_stall_o is high while a word is in progress; the result sits in an output
// register, so the next word is taken while that result waits. A finished result
// is held until the output register frees up when the receiver stalls.
// Reset clears pointer, clock phase and all per-slot valid bits at once: every
// slot reads as idle right after reset, with no clearing pass.
`timescale 1ns / 1ps

`include "priority_timing_wheel_assert.svh"

module priority_timing_wheel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptw_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptw_pkg::out_word_t out_word_o
);

  import ptw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam logic [ADDR_W-1:0] LAST_STEP = ADDR_W'(WHEEL_SLOTS - 1);
  localparam logic [ADDR_W-1:0] ONE_STEP  = ADDR_W'(1);

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic              phase_q, phase_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] walked_q, walked_d;
  logic [DEV_W-1:0]  cdev_q, cdev_d;
  logic [PAY_W-1:0]  cpay_q, cpay_d;
  logic              disp_q, disp_d;
  out_word_t         res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  slot_req_t         req;
  slot_t             rd_slot;
  logic              in_acc;
  logic [ADDR_W+DELAY_W-1:0] start_sum;
  logic [ADDR_W-1:0] start_pos;
  logic [ADDR_W-1:0] ptr_next;
  logic [ADDR_W-1:0] pos_next;

  ptw_slot_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rd_slot_o(rd_slot)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign start_sum = {{DELAY_W{1'b0}}, ptr_q} + {{ADDR_W{1'b0}}, in_word_i.delay};
  assign start_pos = start_sum[ADDR_W-1:0];
  assign ptr_next  = ptr_q + ONE_STEP;
  assign pos_next  = pos_q + ONE_STEP;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    walked_d    = walked_q;
    cdev_d      = cdev_q;
    cpay_d      = cpay_q;
    disp_d      = disp_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    req         = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_word_i.operation == OP_DISPATCH) begin
            phase_d = ~phase_q;
            if (!phase_q) begin
              res_d   = '{status: ST_CLOCK, disp_device: '0, event_payload: '0};
              state_d = S_OUT;
            end else begin
              ptr_d       = ptr_next;
              pos_d       = ptr_next;
              req.rd_en   = 1'b1;
              req.rd_addr = ptr_next;
              disp_d      = 1'b1;
              state_d     = S_CMP;
            end
          end else begin
            pos_d       = start_pos;
            walked_d    = '0;
            cdev_d      = in_word_i.device_code;
            cpay_d      = in_word_i.payload;
            req.rd_en   = 1'b1;
            req.rd_addr = start_pos;
            disp_d      = 1'b0;
            state_d     = S_CMP;
          end
        end
      end

      S_CMP: begin
        if (disp_q) begin
          // Report the slot, then mark it idle; the argument word stays.
          res_d = '{status: ST_EVENT, disp_device: rd_slot.device,
                    event_payload: rd_slot.payload};
          req.wr_en           = 1'b1;
          req.wr_addr         = pos_q;
          req.wr_slot.device  = IDLE_CODE;
          req.wr_slot.payload = rd_slot.payload;
          state_d             = S_OUT;
        end else if (rd_slot.device <= cdev_q) begin
          // Equal or higher priority: walk past, drop after a full circle.
          if (walked_q == LAST_STEP) begin
            res_d   = '{status: ST_DROPPED, disp_device: '0, event_payload: '0};
            state_d = S_OUT;
          end else begin
            pos_d       = pos_next;
            walked_d    = walked_q + ONE_STEP;
            req.rd_en   = 1'b1;
            req.rd_addr = pos_next;
          end
        end else begin
          req.wr_en           = 1'b1;
          req.wr_addr         = pos_q;
          req.wr_slot.device  = cdev_q;
          req.wr_slot.payload = cpay_q;
          if (rd_slot.device == IDLE_CODE) begin
            res_d   = '{status: ST_SCHEDULED, disp_device: '0, event_payload: '0};
            state_d = S_OUT;
          end else begin
            // Carry the displaced entry; the swapped slot already ranks above it.
            cdev_d      = rd_slot.device;
            cpay_d      = rd_slot.payload;
            pos_d       = pos_next;
            walked_d    = ONE_STEP;
            req.rd_en   = 1'b1;
            req.rd_addr = pos_next;
          end
        end
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    walked_q <= walked_d;
    cdev_q   <= cdev_d;
    cpay_q   <= cpay_d;
    disp_q   <= disp_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  `PTW_ASSERT_NEXT(a_accept_busy, in_acc, state_q != S_IDLE, "accepted word did not start work")
  `PTW_ASSERT(a_write_in_cmp, !req.wr_en || state_q == S_CMP, "slot write outside compare step")
  `PTW_ASSERT_NEXT(a_result_loaded, state_q == S_OUT && !(out_valid_q && out_stall_i),
                   out_valid_q && state_q == S_IDLE, "finished result not loaded")

endmodule
